// ===== hdl/krpc_pkg.sv =====
// Shared constants, types and a helper function for the key range prefix counter.
// No dependencies; compiled first.
`default_nettype none

package krpc_pkg;

  localparam int MAX_KEY_BYTES = 32;
  localparam int BYTE_W        = 8;
  localparam int CFG_W         = 9;
  localparam int IDX_W         = 5;
  localparam int REM_W         = 3;
  localparam int SHIFT_W       = 4;
  localparam int COUNT_W       = 64;

  localparam logic [CFG_W-1:0] PREFIX_BITS_RESET = CFG_W'(64);
  localparam logic [CFG_W-1:0] PREFIX_BITS_MAX   = CFG_W'(MAX_KEY_BYTES * BYTE_W);

  // Length settings derived from prefix_bits, held next to the accumulator
  typedef struct packed {
    logic [IDX_W-1:0] last_index;  // index of the final byte of the prefix
    logic [REM_W-1:0] rem;         // bits used from the final byte, 0 means 8
  } len_cfg_t;

  // One result item
  typedef struct packed {
    logic [COUNT_W-1:0] prefix_count;
    logic               overflowed;
  } result_t;

  // Clamp the prefix length and split it into byte count and tail width
  function automatic len_cfg_t derive_len(input logic [CFG_W-1:0] pb);
    logic [CFG_W-1:0] eff;
    logic [CFG_W-1:0] needed;
    len_cfg_t         cfg_v;
    eff = pb;
    if (pb == '0) begin
      eff = CFG_W'(1);
    end else if (pb > PREFIX_BITS_MAX) begin
      eff = PREFIX_BITS_MAX;
    end
    needed           = (eff + CFG_W'(7)) >> 3;
    cfg_v.last_index = IDX_W'(needed - CFG_W'(1));
    cfg_v.rem        = eff[REM_W-1:0];
    return cfg_v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/krpc_ifs.sv =====
// Handshake channel interfaces: key byte pairs in, counts out, length config.
// Depends on krpc_pkg.
`default_nettype none

interface krpc_pair_if import krpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] low_byte;
  logic [BYTE_W-1:0] high_byte;
  modport source (output valid, output low_byte, output high_byte, input ready);
  modport sink   (input valid, input low_byte, input high_byte, output ready);
endinterface

interface krpc_count_if import krpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] prefix_count;
  logic               overflowed;
  modport source (output valid, output prefix_count, output overflowed, input ready);
  modport sink   (input valid, input prefix_count, input overflowed, output ready);
endinterface

interface krpc_cfg_if import krpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] prefix_bits;
  modport source (output valid, output prefix_bits, input ready);
  modport sink   (input valid, input prefix_bits, output ready);
endinterface

`default_nettype wire

// ===== hdl/krpc_accum.sv =====
// Prefix length register plus the 64-bit shift/add accumulator with overflow tracking.
// Depends on krpc_pkg.
`default_nettype none

module krpc_accum import krpc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr,
  input  wire logic [CFG_W-1:0]  cfg_bits,
  input  wire logic              advance,
  input  wire logic [BYTE_W-1:0] low_byte,
  input  wire logic [BYTE_W-1:0] high_byte,
  output logic                   is_last,
  output result_t                result
);

  len_cfg_t           len_cfg;
  logic [COUNT_W-1:0] accumulator;
  logic [IDX_W-1:0]   byte_index;
  logic               overflow_seen;

  logic [SHIFT_W-1:0] width;
  logic [BYTE_W-1:0]  lo_bits;
  logic [BYTE_W-1:0]  hi_bits;
  logic               shift_ovf;
  logic [COUNT_W-1:0] shifted;
  logic [COUNT_W:0]   sum;
  logic               ovf_step;
  logic [COUNT_W-1:0] acc_step;
  logic               final_ovf;

  assign is_last = (byte_index == len_cfg.last_index);

  // Tail byte uses only its top rem bits
  assign width   = (is_last && len_cfg.rem != '0) ? SHIFT_W'(len_cfg.rem) : SHIFT_W'(BYTE_W);
  assign lo_bits = low_byte  >> (SHIFT_W'(BYTE_W) - width);
  assign hi_bits = high_byte >> (SHIFT_W'(BYTE_W) - width);

  // total = total * 2^w + hi - lo, flag if the shift or the add leaves 64 bits
  assign shift_ovf = |(accumulator & ~({COUNT_W{1'b1}} >> width));
  assign shifted   = accumulator << width;
  assign sum       = {1'b0, shifted} + (COUNT_W+1)'(hi_bits);
  assign ovf_step  = overflow_seen | shift_ovf | sum[COUNT_W];
  assign acc_step  = ovf_step ? accumulator : (sum[COUNT_W-1:0] - COUNT_W'(lo_bits));

  // The final +1 overflows when the total is all ones
  assign final_ovf           = ovf_step | (acc_step == {COUNT_W{1'b1}});
  assign result.overflowed   = final_ovf;
  assign result.prefix_count = final_ovf ? '0 : (acc_step + COUNT_W'(1));

  // Run state: cleared by reset, config writes and each emitted result
  always_ff @(posedge clk) begin
    if (rst) begin
      len_cfg       <= derive_len(PREFIX_BITS_RESET);
      accumulator   <= '0;
      byte_index    <= '0;
      overflow_seen <= 1'b0;
    end else if (cfg_wr) begin
      len_cfg       <= derive_len(cfg_bits);
      accumulator   <= '0;
      byte_index    <= '0;
      overflow_seen <= 1'b0;
    end else if (advance) begin
      if (is_last) begin
        accumulator   <= '0;
        byte_index    <= '0;
        overflow_seen <= 1'b0;
      end else begin
        accumulator   <= acc_step;
        byte_index    <= byte_index + IDX_W'(1);
        overflow_seen <= ovf_step;
      end
    end
  end

  // Byte counter never runs past the final byte of the prefix
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    byte_index <= len_cfg.last_index)
    else $error("byte index beyond prefix length");

  // A finished key leaves a clean run behind
  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    (advance && is_last) |=> (byte_index == '0 && accumulator == '0 && !overflow_seen))
    else $error("run state not cleared after result");

endmodule

`default_nettype wire

// ===== hdl/krpc_out_reg.sv =====
// Result register driving the count channel; frees its slot as the item is taken.
// Depends on krpc_pkg and krpc_ifs.
`default_nettype none

module krpc_out_reg import krpc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     load,
  input  result_t       res,
  output logic          slot_free,
  krpc_count_if.source  counts
);

  logic    out_valid;
  result_t out_data;

  assign slot_free           = !out_valid || counts.ready;
  assign counts.valid        = out_valid;
  assign counts.prefix_count = out_data.prefix_count;
  assign counts.overflowed   = out_data.overflowed;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (counts.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

  // An overflowed result always carries a zero count
  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.overflowed) |-> (out_data.prefix_count == '0))
    else $error("overflowed result with nonzero count");

endmodule

`default_nettype wire

// ===== hdl/key_range_prefix_counter.sv =====
// Key range prefix counter: byte-pair input register, accumulator, result register.
// A key's final byte pair passes the input stage, then the result register, before its count is offered.
// Throughput: one byte pair per cycle except when held as below; one shift-add-subtract pass each.
// A full result register that is not being taken holds the final byte in the input stage.
// Reset (rst, synchronous): prefix_bits = 64, accumulator/index/overflow cleared, no items held.
// Depends on krpc_pkg, krpc_ifs, krpc_accum and krpc_out_reg.
`default_nettype none

module key_range_prefix_counter import krpc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  krpc_cfg_if.sink    cfg,
  krpc_pair_if.sink   keys,
  krpc_count_if.source counts
);

  logic              stg_valid;
  logic [BYTE_W-1:0] stg_lo;
  logic [BYTE_W-1:0] stg_hi;
  logic              stg_advance;
  logic              is_last;
  logic              slot_free;
  logic              key_fire;
  result_t           result;

  assign cfg.ready   = 1'b1;
  // Non-final bytes always move on; the final one needs room in the result register
  assign stg_advance = stg_valid && (!is_last || slot_free);
  assign keys.ready  = !stg_valid || stg_advance;
  assign key_fire    = keys.valid && keys.ready;

  // Input stage valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (keys.ready) begin
      stg_valid <= keys.valid;
    end
  end

  // Input stage payload
  always_ff @(posedge clk) begin
    if (key_fire) begin
      stg_lo <= keys.low_byte;
      stg_hi <= keys.high_byte;
    end
  end

  krpc_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg.valid && cfg.ready),
    .cfg_bits  (cfg.prefix_bits),
    .advance   (stg_advance),
    .low_byte  (stg_lo),
    .high_byte (stg_hi),
    .is_last   (is_last),
    .result    (result)
  );

  krpc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (stg_advance && is_last),
    .res       (result),
    .slot_free (slot_free),
    .counts    (counts)
  );

  // A held input item keeps its bytes
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (stg_valid && !stg_advance) |=> (stg_valid && $stable(stg_lo) && $stable(stg_hi)))
    else $error("stalled input stage lost its item");

  // A final byte never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (stg_advance && is_last) |-> (!counts.valid || counts.ready))
    else $error("result register overwritten");

endmodule

`default_nettype wire

// ===== bench/krpc_check_pkg.sv =====
// Expected-count tracking for the key range prefix counter bench.
// Holds the prefix length setting, the running per-key total and the queue of counts due.
// Depends on krpc_pkg.
`timescale 1ns / 100ps

package krpc_check_pkg;
  import krpc_pkg::*;

  // Prefix length after clamping: zero means one bit, the top is MAX_KEY_BYTES bytes
  function automatic int unsigned effective_prefix_bits(input logic [CFG_W-1:0] bits);
    if (bits == '0) begin
      return 1;
    end
    if (bits > PREFIX_BITS_MAX) begin
      return MAX_KEY_BYTES * BYTE_W;
    end
    return 32'(bits);
  endfunction

  class prefix_count_board;
    logic [CFG_W-1:0]   prefix_bits      = PREFIX_BITS_RESET;
    logic [COUNT_W-1:0] running_total    = '0;
    int unsigned        bytes_taken      = 0;
    bit                 total_overflowed = 1'b0;
    result_t            counts_due[$];
    int unsigned        counts_checked   = 0;
    int unsigned        overflow_counts  = 0;
    int unsigned        mismatches       = 0;

    function void clear_key();
      running_total    = '0;
      bytes_taken      = 0;
      total_overflowed = 1'b0;
    endfunction

    // A length write also drops any key in progress
    function void set_prefix(input logic [CFG_W-1:0] bits);
      prefix_bits = bits;
      clear_key();
    endfunction

    // Fold one accepted byte pair into the total; queue a count after the last byte
    function void note_pair(input logic [BYTE_W-1:0] low, input logic [BYTE_W-1:0] high);
      int unsigned        eff;
      int unsigned        need;
      int unsigned        width;
      bit                 final_byte;
      logic [COUNT_W-1:0] lo_v;
      logic [COUNT_W-1:0] hi_v;
      result_t            due;
      eff        = effective_prefix_bits(prefix_bits);
      need       = (eff + 7) / 8;
      final_byte = (bytes_taken + 1 >= need);
      width      = (final_byte && (eff % 8) != 0) ? eff % 8 : 8;
      lo_v       = COUNT_W'(low) >> (8 - width);
      hi_v       = COUNT_W'(high) >> (8 - width);

      // After an overflow the rest of the key passes through untouched
      if (!total_overflowed) begin
        if (running_total > ({COUNT_W{1'b1}} >> width)) begin
          total_overflowed = 1'b1;
        end else begin
          running_total = running_total << width;
          if (running_total > {COUNT_W{1'b1}} - hi_v) begin
            total_overflowed = 1'b1;
          end else begin
            running_total = running_total + hi_v - lo_v;
          end
        end
      end

      if (!final_byte) begin
        bytes_taken++;
        return;
      end

      // The +1 itself can wrap when the total is all ones
      if (!total_overflowed && running_total == {COUNT_W{1'b1}}) begin
        total_overflowed = 1'b1;
      end
      due.prefix_count = total_overflowed ? '0 : running_total + 1'b1;
      due.overflowed   = total_overflowed;
      counts_due.push_back(due);
      clear_key();
    endfunction

    function void report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) begin
        $display("count mismatch: %s", what);
      end
    endfunction

    // Compare one accepted count against the oldest one due
    function void check_count(input logic [COUNT_W-1:0] count, input logic ovf);
      result_t due;
      counts_checked++;
      if (counts_due.size() == 0) begin
        report_mismatch($sformatf("unexpected count %h overflowed %b", count, ovf));
        return;
      end
      due = counts_due.pop_front();
      if (due.overflowed) begin
        overflow_counts++;
      end
      if (count !== due.prefix_count) begin
        report_mismatch($sformatf("prefix_count expected %h actual %h",
                                  due.prefix_count, count));
      end
      if (ovf !== due.overflowed) begin
        report_mismatch($sformatf("overflowed expected %b actual %b", due.overflowed, ovf));
      end
    endfunction
  endclass

endpackage

// ===== bench/key_range_prefix_counter_test.sv =====
// Self-checking bench for key_range_prefix_counter: directed and random key ranges
// under random source gaps and sink stalls, checked against prefix_count_board.
// Depends on krpc_pkg, krpc_ifs, krpc_check_pkg and the block itself.
`timescale 1ns / 100ps

module key_range_prefix_counter_test;
  import krpc_pkg::*;
  import krpc_check_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_WAIT  = 4;
  localparam int TAIL_WAIT    = 10;
  localparam int RANDOM_PAIRS = 400;

  logic clk = 1'b0;
  logic rst;

  krpc_cfg_if   cfg_ch ();
  krpc_pair_if  key_ch ();
  krpc_count_if count_ch ();

  key_range_prefix_counter dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .keys   (key_ch),
    .counts (count_ch)
  );

  prefix_count_board board = new;

  int unsigned cycle_count   = 0;
  int unsigned pairs_sent    = 0;
  int unsigned keys_sent     = 0;
  int unsigned writes_done   = 0;
  bit          gaps_on       = 1'b1;
  bit          sink_steady   = 1'b0;
  int unsigned sink_hold_req = 0;

  always #1 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Count sink: check accepted items, then pick the next ready level
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;
  int unsigned run_left   = 0;
  int unsigned pick;

  always @(posedge clk) begin
    if (rst) begin
      count_ch.ready <= 1'b0;
    end else begin
      if (count_ch.valid && count_ch.ready) begin
        board.check_count(count_ch.prefix_count, count_ch.overflowed);
      end
      if (sink_hold_req != 0) begin
        hold_left     = sink_hold_req;
        sink_hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        count_ch.ready <= 1'b0;
      end else if (sink_steady) begin
        count_ch.ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        count_ch.ready <= 1'b0;
      end else if (run_left != 0) begin
        run_left--;
        count_ch.ready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          run_left = $urandom_range(1, 40);
          count_ch.ready <= 1'b1;
        end else if (pick < 9) begin
          stall_left = $urandom_range(0, 2);
          count_ch.ready <= 1'b0;
        end else begin
          stall_left = $urandom_range(10, 60);
          count_ch.ready <= 1'b0;
        end
      end
    end
  end

  // Source idle time after an item: mostly none or short, now and then long
  task automatic source_gap();
    int unsigned r;
    int unsigned n;
    if (!gaps_on) begin
      return;
    end
    r = $urandom_range(0, 19);
    n = (r < 10) ? 0 : (r < 18) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (n != 0) begin
      key_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offer one byte pair and hold it until taken
  task automatic send_pair(input logic [BYTE_W-1:0] low, input logic [BYTE_W-1:0] high);
    key_ch.valid     <= 1'b1;
    key_ch.low_byte  <= low;
    key_ch.high_byte <= high;
    @(posedge clk);
    while (!key_ch.ready) @(posedge clk);
    board.note_pair(low, high);
    pairs_sent++;
    source_gap();
  endtask

  task automatic wait_counts_drained();
    while (board.counts_due.size() != 0) @(posedge clk);
  endtask

  // Length writes only go in while the block is idle
  task automatic write_prefix(input logic [CFG_W-1:0] bits);
    key_ch.valid <= 1'b0;
    wait_counts_drained();
    repeat (SETTLE_WAIT) @(posedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.prefix_bits <= bits;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    board.set_prefix(bits);
    writes_done++;
  endtask

  // Send the first sent_bytes pairs of an nbytes key. The bounds agree over a random
  // leading stretch so long keys can stay in range; past it the bytes are free.
  task automatic send_key(input int unsigned nbytes, input int unsigned sent_bytes);
    int unsigned       shared;
    bit                ordered;
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] tmp;
    case ($urandom_range(0, 3))
      0: shared = 0;
      1: shared = $urandom_range(0, nbytes);
      default: shared = (nbytes > 8) ? $urandom_range(nbytes - 8, nbytes) : 0;
    endcase
    ordered = ($urandom_range(0, 3) != 0);
    for (int unsigned i = 0; i < sent_bytes; i++) begin
      lo = 8'($urandom_range(0, 255));
      hi = (i < shared) ? lo : 8'($urandom_range(0, 255));
      if (i == shared && ordered && lo > hi) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      send_pair(lo, hi);
    end
    if (sent_bytes == nbytes) begin
      keys_sent++;
    end
  endtask

  task automatic run_directed();
    // Reset length of 64 bits, full range: the count is 2^64, so the result overflows
    repeat (8) send_pair(8'h00, 8'hFF);
    keys_sent++;
    // Whole bytes, including a reversed range that wraps
    write_prefix(CFG_W'(8));
    send_pair(8'h00, 8'hFF);
    send_pair(8'hFF, 8'h00);
    send_pair(8'hFF, 8'hFF);
    send_pair(8'h00, 8'h00);
    // Zero length acts as one bit; a reversed bit gives an all-ones total
    write_prefix(CFG_W'(0));
    send_pair(8'h80, 8'h7F);
    send_pair(8'h00, 8'hFF);
    // Partial byte, low bits ignored
    write_prefix(CFG_W'(3));
    send_pair(8'hE0, 8'h1F);
    send_pair(8'h1F, 8'hE0);
    // Reversed first byte overflows on the next shift
    write_prefix(CFG_W'(16));
    send_pair(8'hFF, 8'h00);
    send_pair(8'h12, 8'h34);
    // Key in progress is dropped by a length write
    send_pair(8'h00, 8'h01);
    write_prefix(CFG_W'(9));
    send_pair(8'h00, 8'hFF);
    send_pair(8'h00, 8'h80);
    keys_sent += 10;
  endtask

  // Sink holds off while the source keeps offering one-byte keys
  task automatic run_backpressure();
    write_prefix(CFG_W'(5));
    gaps_on       = 1'b0;
    sink_steady   = 1'b0;
    sink_hold_req = 150;
    repeat (24) send_key(1, 1);
    gaps_on = 1'b1;
    key_ch.valid <= 1'b0;
    wait_counts_drained();
  endtask

  task automatic run_random();
    logic [CFG_W-1:0] forced_bits[7];
    logic [CFG_W-1:0] bits;
    int unsigned      stop_at;
    int unsigned      phase_no;
    int unsigned      nbytes;
    int unsigned      nkeys;
    forced_bits = '{CFG_W'(1), CFG_W'(256), CFG_W'(257), CFG_W'(511),
                    CFG_W'(255), CFG_W'(63), CFG_W'(65)};
    stop_at  = pairs_sent + RANDOM_PAIRS;
    phase_no = 0;
    while (pairs_sent < stop_at) begin
      // Mostly short prefixes, now and then long or out of range ones
      if (phase_no < 7) begin
        bits = forced_bits[phase_no];
      end else begin
        case ($urandom_range(0, 9))
          6, 7:    bits = forced_bits[$urandom_range(0, 6)];
          8:       bits = CFG_W'($urandom_range(65, 256));
          9:       bits = CFG_W'($urandom_range(0, 511));
          default: bits = CFG_W'($urandom_range(1, 64));
        endcase
      end
      write_prefix(bits);
      gaps_on     = ($urandom_range(0, 4) != 0);
      sink_steady = ($urandom_range(0, 4) == 0);
      nbytes      = (effective_prefix_bits(bits) + 7) / 8;
      nkeys       = (nbytes <= 8) ? $urandom_range(3, 12) : $urandom_range(1, 3);
      repeat (nkeys) send_key(nbytes, nbytes);
      // Source pauses until every count is in before going on
      if (phase_no == 10) begin
        key_ch.valid <= 1'b0;
        wait_counts_drained();
        send_key(nbytes, nbytes);
      end
      // Now and then a key cut short by the next length write
      if (nbytes > 1 && $urandom_range(0, 4) == 0) begin
        send_key(nbytes, $urandom_range(1, nbytes - 1));
      end
      phase_no++;
    end
    gaps_on     = 1'b1;
    sink_steady = 1'b0;
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.prefix_bits <= '0;
    key_ch.valid       <= 1'b0;
    key_ch.low_byte    <= '0;
    key_ch.high_byte   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_backpressure();
    run_random();

    key_ch.valid <= 1'b0;
    wait_counts_drained();
    repeat (TAIL_WAIT) @(posedge clk);

    $display("sent %0d byte pairs forming %0d full keys across %0d length writes",
             pairs_sent, keys_sent, writes_done);
    $display("checked %0d counts, %0d of them overflow results",
             board.counts_checked, board.overflow_counts);
    if (board.mismatches == 0 && board.counts_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d counts still due",
               board.mismatches, board.counts_due.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
